FILE: rtl/core/sofq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sofq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TOTAL_W = 5;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef struct packed {
        logic [15:0] seq;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [1:0]  kind;
        logic [15:0] tag;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   push_en;
        logic   pop_en;
        entry_t item;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/sofq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sofq_cell (
    input  wire logic               clk,
    input  wire sofq_pkg::cell_ctl_t ctl,
    input  wire logic               occupied,
    input  wire logic               prev_gt,
    input  wire sofq_pkg::entry_t   prev_data,
    input  wire sofq_pkg::entry_t   next_data,
    output sofq_pkg::entry_t        data,
    output sofq_pkg::entry_t        data_next,
    output logic                    gt
);
    import sofq_pkg::*;

    entry_t data_reg;

    // strict compare: equal keys stay ahead of the new entry
    assign gt   = occupied && (data_reg.seq > ctl.item.seq);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.push_en)
        begin
            if (prev_gt)
            begin
                data_next = prev_data;
            end
            else if (gt || !occupied)
            begin
                data_next = ctl.item;
            end
        end
        else if (ctl.pop_en)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/sequence_ordered_frame_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted frame descriptor queue, up to DEPTH entries in ascending seq_number.
// Input channel: item_valid / item_stall with operation (push or pop) and the
// descriptor fields, which a pop ignores. Output channel: result_valid /
// result_stall, one result per input transfer: head after the operation,
// entry_total after it, and rejected (push into a full queue or pop of an
// empty one; the queue is then unchanged).
// The result is registered and appears the cycle after the input transfer.
// Throughput: one item per cycle while the result is not stalled. The store is a
// chain of cells; on a push every cell compares its key against the broadcast
// descriptor and takes either its left neighbor, the new descriptor, or keeps
// its own, so an insert or a pop updates all cells together.
// Reset empties the queue (count cleared) and drops any pending result.
// When the receiver stalls, the result register holds and item_stall is
// raised until the result is taken.
module sequence_ordered_frame_queue_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        operation,
    input  wire logic [15:0] seq_number,
    input  wire logic [7:0]  source_station,
    input  wire logic [7:0]  dest_station,
    input  wire logic [1:0]  frame_kind,
    input  wire logic [15:0] payload_tag,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             head_valid,
    output logic [15:0]      head_seq,
    output logic [7:0]       head_source,
    output logic [7:0]       head_dest,
    output logic [1:0]       head_kind,
    output logic [15:0]      head_tag,
    output logic [sofq_pkg::TOTAL_W-1:0] entry_total,
    output logic             rejected
);
    import sofq_pkg::*;

    logic             accept;
    logic             full;
    logic             empty;
    logic             reject_now;
    cell_ctl_t        ctl;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    entry_t           head_reg;
    entry_t           head_next;
    logic             head_valid_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic             rejected_reg;

    entry_t           cell_q    [DEPTH];
    entry_t           cell_d    [DEPTH];
    logic             cell_gt   [DEPTH];
    logic             cell_occ  [DEPTH];

    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);

    always_comb
    begin
        ctl.item.seq  = seq_number;
        ctl.item.src  = source_station;
        ctl.item.dst  = dest_station;
        ctl.item.kind = frame_kind;
        ctl.item.tag  = payload_tag;
        ctl.push_en   = 1'b0;
        ctl.pop_en    = 1'b0;
        reject_now    = 1'b0;
        count_next    = count_reg;
        if (accept)
        begin
            case (op_t'(operation))
                OP_PUSH:
                begin
                    if (full)
                    begin
                        reject_now = 1'b1;
                    end
                    else
                    begin
                        ctl.push_en = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (empty)
                    begin
                        reject_now = 1'b1;
                    end
                    else
                    begin
                        ctl.pop_en = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    reject_now = 1'b0;
                end
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign cell_occ[i] = (CNT_W'(i) < count_reg);
            if (i == 0)
            begin : g_first
                sofq_cell u_cell (
                    .clk       (clk),
                    .ctl       (ctl),
                    .occupied  (cell_occ[i]),
                    .prev_gt   (1'b0),
                    .prev_data (ctl.item),
                    .next_data (cell_q[i+1]),
                    .data      (cell_q[i]),
                    .data_next (cell_d[i]),
                    .gt        (cell_gt[i])
                );
            end
            else if (i == DEPTH - 1)
            begin : g_last
                sofq_cell u_cell (
                    .clk       (clk),
                    .ctl       (ctl),
                    .occupied  (cell_occ[i]),
                    .prev_gt   (cell_gt[i-1]),
                    .prev_data (cell_q[i-1]),
                    .next_data (cell_q[i]),
                    .data      (cell_q[i]),
                    .data_next (cell_d[i]),
                    .gt        (cell_gt[i])
                );
            end
            else
            begin : g_mid
                sofq_cell u_cell (
                    .clk       (clk),
                    .ctl       (ctl),
                    .occupied  (cell_occ[i]),
                    .prev_gt   (cell_gt[i-1]),
                    .prev_data (cell_q[i-1]),
                    .next_data (cell_q[i+1]),
                    .data      (cell_q[i]),
                    .data_next (cell_d[i]),
                    .gt        (cell_gt[i])
                );
            end
        end
    endgenerate

    // head fields read as zero when the queue ends up empty
    assign head_next = (count_next == '0) ? '0 : cell_d[0];

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (accept)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_reg       <= head_next;
            head_valid_reg <= (count_next != '0);
            total_reg      <= TOTAL_W'(count_next);
            rejected_reg   <= reject_now;
        end
    end

    assign result_valid = result_valid_reg;
    assign head_valid   = head_valid_reg;
    assign head_seq     = head_reg.seq;
    assign head_source  = head_reg.src;
    assign head_dest    = head_reg.dst;
    assign head_kind    = head_reg.kind;
    assign head_tag     = head_reg.tag;
    assign entry_total  = total_reg;
    assign rejected     = rejected_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sofq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sofq_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire logic        item_stall,
    input  wire logic        result_valid,
    input  wire logic        result_stall,
    input  wire logic        head_valid,
    input  wire logic [15:0] head_seq,
    input  wire logic [15:0] head_tag,
    input  wire logic [sofq_pkg::TOTAL_W-1:0] entry_total
);
    import sofq_pkg::*;

    // every input transfer produces a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> result_valid)
        else $error("no result after input transfer");

    // head_valid tracks the count
    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (head_valid == (entry_total != '0)))
        else $error("head_valid disagrees with entry_total");

    // an empty queue shows zero head fields
    a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !head_valid) |-> (head_seq == '0 && head_tag == '0))
        else $error("empty queue shows nonzero head");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (entry_total <= TOTAL_W'(DEPTH)))
        else $error("entry_total above depth");

    // a pending result blocks the input side
    a_stall_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> item_stall)
        else $error("input taken while result held");

endmodule

bind sequence_ordered_frame_queue_core sofq_checker u_sofq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .head_valid   (head_valid),
    .head_seq     (head_seq),
    .head_tag     (head_tag),
    .entry_total  (entry_total)
);

`default_nettype wire
